@@ hdl/ebegs_pkg.sv @@
// Shared types and command codes for the element sweep engine.
package ebegs_pkg;

  localparam int DOFS       = 12;
  localparam int COEF_COUNT = DOFS * DOFS;

  localparam logic [2:0] CMD_WR_VEC  = 3'd0;
  localparam logic [2:0] CMD_LD_COEF = 3'd1;
  localparam logic [2:0] CMD_LD_IDX  = 3'd2;
  localparam logic [2:0] CMD_SW_LO   = 3'd3;
  localparam logic [2:0] CMD_SW_UP   = 3'd4;
  localparam logic [2:0] CMD_RD_VEC  = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GIDX,
    S_GVEC,
    S_GSTORE,
    S_ROW,
    S_MAC,
    S_DRAIN,
    S_SIDX,
    S_SWR,
    S_RD
  } state_t;

endpackage

@@ hdl/ebe_block_gauss_seidel_sweep.sv @@
// Element-by-element block Gauss-Seidel sweep engine, top level.
//
// Load and write commands finish in the idle state; a read passes through
// S_RD. A sweep runs 12 gathers (index RAM read, then vector RAM read), 8
// row updates through the one shared multiplier at one term a cycle, each
// with a start and a pipeline drain, then 8 scatters (index RAM read, then
// vector RAM write). One transaction is in work at a time; a result waits
// in the output register and the next transaction is taken once that
// register is free or being emptied. No clearing pass runs after reset: the
// dummy slot reads as zero by compare.
module ebe_block_gauss_seidel_sweep
  import ebegs_pkg::*;
#(
  parameter int VECTOR_DEPTH = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_cmd,
  input  logic [11:0]        in_vec_addr,
  input  logic signed [31:0] in_vec_value,
  input  logic [7:0]         in_coef_slot,
  input  logic signed [31:0] in_coef_value,
  input  logic [3:0]         in_dof_slot,
  input  logic [11:0]        in_eq_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_read_value,
  output logic               out_saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [11:0]        cfg_data
);

  localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

  state_t state_r, state_nxt;

  logic signed [31:0] vec_mem [VECTOR_DEPTH];
  logic signed [31:0] coef_mem [COEF_COUNT];
  logic [11:0]        idx_mem [DOFS];
  logic signed [31:0] z_r [DOFS];

  logic [11:0] dummy_r;
  logic [3:0]  cnt_r;
  logic [2:0]  term_r;
  logic        lower_r;
  logic        ok_r;
  logic        sat_r;

  logic signed [31:0] vec_q;
  logic signed [31:0] coef_q;
  logic [11:0]        idx_q;

  logic               p1_v_r, p1_last_r, p2_v_r, p2_last_r;
  logic [3:0]         p1_col_r;
  logic signed [63:0] prod_r;
  logic signed [47:0] acc_r;

  logic               out_valid_r, out_sat_r;
  logic signed [31:0] out_val_r;

  logic        in_acc, out_take, out_set;
  logic        vwe;
  logic [11:0] vwa, vra;
  logic signed [31:0] vwd;
  logic [3:0]  ira;
  logic [3:0]  row, col, zsel;
  logic [2:0]  last_term;
  logic [7:0]  coef_ra;
  logic signed [31:0] zrd;
  logic signed [63:0] prod_rnd;
  logic signed [47:0] acc_nxt;
  logic signed [31:0] acc_sat;
  logic        acc_ovf;

  function automatic logic addr_ok(input logic [11:0] a, input logic [11:0] d);
    addr_ok = (a != d) && (32'(a) < VECTOR_DEPTH);
  endfunction

  assign out_take  = out_valid_r && !out_stall;
  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // a result is loaded at the end of every transaction
  assign out_set = ((state_r == S_IDLE) && in_acc && in_cmd != CMD_SW_LO &&
                    in_cmd != CMD_SW_UP && in_cmd != CMD_RD_VEC) ||
                   ((state_r == S_SWR) && (cnt_r == 4'd7)) ||
                   (state_r == S_RD);

  assign out_valid      = out_valid_r;
  assign out_read_value = out_val_r;
  assign out_saturated  = out_sat_r;

  // row schedule: lower does rows 4..11, upper does rows 4..7 then 0..3
  always_comb begin
    if (lower_r) begin
      row = cnt_r + 4'd4;
      col = 4'(term_r);
    end else begin
      row = cnt_r[2] ? {2'b00, cnt_r[1:0]} : {2'b01, cnt_r[1:0]};
      col = (cnt_r[2] ? 4'd4 : 4'd8) + 4'(term_r);
    end
    last_term = cnt_r[2] ? 3'd7 : 3'd3;
    coef_ra   = 8'(row) * 8'd12 + 8'(col);
  end

  always_comb begin
    unique case (state_r)
      S_ROW:         zsel = row;
      S_SIDX, S_SWR: zsel = lower_r ? cnt_r + 4'd4 : cnt_r;
      default:       zsel = p1_col_r;
    endcase
    zrd = (zsel < 4'(DOFS)) ? z_r[zsel] : 32'sd0;
  end

  // round half up, then subtract and clamp
  always_comb begin
    prod_rnd = (prod_r + 64'sd8388608) >>> 24;
    acc_nxt  = acc_r - 48'(prod_rnd);
    acc_ovf  = (acc_nxt > 48'sd2147483647) || (acc_nxt < -48'sd2147483648);
    if (acc_nxt > 48'sd2147483647)       acc_sat = 32'sh7fffffff;
    else if (acc_nxt < -48'sd2147483648) acc_sat = -32'sh80000000;
    else                                 acc_sat = acc_nxt[31:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_SW_LO || in_cmd == CMD_SW_UP) state_nxt = S_GIDX;
          else if (in_cmd == CMD_RD_VEC)                  state_nxt = S_RD;
        end
      end
      S_GIDX:   state_nxt = S_GVEC;
      S_GVEC:   state_nxt = S_GSTORE;
      S_GSTORE: state_nxt = (cnt_r == 4'(DOFS - 1)) ? S_ROW : S_GIDX;
      S_ROW:    state_nxt = S_MAC;
      S_MAC:    if (term_r == last_term) state_nxt = S_DRAIN;
      S_DRAIN: begin
        if (p2_v_r && p2_last_r) state_nxt = (cnt_r == 4'd7) ? S_SIDX : S_ROW;
      end
      S_SIDX:   state_nxt = S_SWR;
      S_SWR:    state_nxt = (cnt_r == 4'd7) ? S_IDLE : S_SIDX;
      S_RD:     state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    vwe = 1'b0;
    vwa = in_vec_addr;
    vwd = in_vec_value;
    vra = in_vec_addr;
    ira = cnt_r;
    unique case (state_r)
      S_IDLE: vwe = in_acc && (in_cmd == CMD_WR_VEC) && addr_ok(in_vec_addr, dummy_r);
      S_GVEC: vra = idx_q;
      S_SIDX: ira = lower_r ? cnt_r + 4'd4 : cnt_r;
      S_SWR: begin
        vwe = addr_ok(idx_q, dummy_r);
        vwa = idx_q;
        vwd = zrd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (vwe) vec_mem[AW'(vwa)] <= vwd;
    vec_q <= vec_mem[AW'(vra)];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_cmd == CMD_LD_COEF && in_coef_slot < 8'(COEF_COUNT))
      coef_mem[in_coef_slot] <= in_coef_value;
    coef_q <= coef_mem[coef_ra];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_cmd == CMD_LD_IDX && in_dof_slot < 4'(DOFS))
      idx_mem[in_dof_slot] <= in_eq_index;
    idx_q <= idx_mem[ira];
  end

  // local values and multiply-accumulate pipeline
  always_ff @(posedge clk) begin
    if (state_r == S_GSTORE) z_r[cnt_r] <= ok_r ? vec_q : 32'sd0;
    else if (state_r == S_DRAIN && p2_v_r && p2_last_r) z_r[row] <= acc_sat;
    if (state_r == S_GVEC) ok_r <= addr_ok(idx_q, dummy_r);
    else if (in_acc) ok_r <= addr_ok(in_vec_addr, dummy_r);
    p1_col_r  <= col;
    p1_last_r <= (term_r == last_term);
    prod_r    <= coef_q * zrd;
    p2_last_r <= p1_last_r;
    if (state_r == S_ROW) acc_r <= 48'(zrd);
    else if (p2_v_r) acc_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dummy_r     <= 12'd0;
      cnt_r       <= 4'd0;
      term_r      <= 3'd0;
      lower_r     <= 1'b0;
      sat_r       <= 1'b0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_sat_r   <= 1'b0;
      out_val_r   <= 32'sd0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) dummy_r <= cfg_data;
      p1_v_r <= (state_r == S_MAC);
      p2_v_r <= p1_v_r;
      if (out_set) out_valid_r <= 1'b1;
      else if (out_take) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          cnt_r   <= 4'd0;
          sat_r   <= 1'b0;
          lower_r <= (in_cmd == CMD_SW_LO);
          if (out_set) begin
            out_val_r <= 32'sd0;
            out_sat_r <= 1'b0;
          end
        end
        S_GSTORE: cnt_r <= (cnt_r == 4'(DOFS - 1)) ? 4'd0 : cnt_r + 4'd1;
        S_ROW:    term_r <= 3'd0;
        S_MAC:    term_r <= term_r + 3'd1;
        S_DRAIN: begin
          if (p2_v_r && p2_last_r) begin
            if (acc_ovf) sat_r <= 1'b1;
            cnt_r <= (cnt_r == 4'd7) ? 4'd0 : cnt_r + 4'd1;
          end
        end
        S_SWR: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd7) begin
            out_val_r <= 32'sd0;
            out_sat_r <= sat_r;
          end
        end
        S_RD: begin
          out_val_r <= ok_r ? vec_q : 32'sd0;
          out_sat_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> state_r == S_IDLE) else $error("transaction taken while busy");

  a_row_end_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (p2_v_r && p2_last_r) |-> state_r == S_DRAIN) else $error("row end outside drain");

  a_row_start_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROW |-> !p1_v_r && !p2_v_r) else $error("row start with pipeline busy");

  a_sat_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |-> out_read_value == 32'sd0)
    else $error("saturation flag on a read result");

endmodule
